FILE: design/escape_time_fractal_iterator_defines.svh
// ----------------------------------------------------------------------------
// Escape-time iterator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ETF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etf check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ETF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etf check failed");

`endif

FILE: design/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Types and constants shared by the escape-time iterator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package etf_pkg;

  localparam int          MAX_STAGES_DEF = 255;
  localparam logic [7:0]  MAX_ITERS_RST  = 8'd200;
  localparam int          FRAC_BITS      = 26;
  // 4.0 in Q12.52, the scale of a sum of two Q6.26 squares
  localparam logic [63:0] ESC_LIMIT      = 64'h0040_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
  } etf_in_t;

  typedef struct packed {
    logic [7:0] escape_count;
    logic       in_set;
  } etf_out_t;

  // What travels from one cell to the next along the chain
  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
    logic               done;
    logic [7:0]         count;
  } etf_lane_t;

endpackage

`default_nettype wire

FILE: design/etf_cell.sv
// ----------------------------------------------------------------------------
// etf_cell
// One iteration step z = z*z + c in two register stages: products, then
// escape test and saturated update.
// ----------------------------------------------------------------------------
`default_nettype none

module etf_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [7:0]         limit,
  input  wire logic               vld_i,
  input  wire etf_pkg::etf_lane_t lane_i,
  output logic                    vld_o,
  output etf_pkg::etf_lane_t      lane_o
);

  localparam logic [7:0] IDX_C = 8'(IDX);

  // stage A: products
  logic               a_vld_r;
  logic               a_act_r;
  etf_pkg::etf_lane_t a_lane_r;
  logic signed [63:0] zr2_r;
  logic signed [63:0] zi2_r;
  logic signed [63:0] cross_r;

  // stage B
  logic               b_vld_r;
  etf_pkg::etf_lane_t b_lane_r;
  etf_pkg::etf_lane_t b_lane_nxt;

  logic [63:0]        mag;
  logic               esc;
  logic signed [63:0] re_full;
  logic signed [63:0] im_full;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if ((v[63:31] == '0) || (v[63:31] == '1)) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lane_r <= lane_i;
      a_act_r  <= !lane_i.done && (IDX_C < limit);
      zr2_r    <= lane_i.z_real * lane_i.z_real;
      zi2_r    <= lane_i.z_imag * lane_i.z_imag;
      cross_r  <= lane_i.z_real * lane_i.z_imag;
      b_lane_r <= b_lane_nxt;
    end
  end

  // both squares are non-negative, so the sum fits unsigned 64 bits
  assign mag     = 64'(zr2_r) + 64'(zi2_r);
  assign esc     = mag > etf_pkg::ESC_LIMIT;
  assign re_full = ((zr2_r - zi2_r) >>> etf_pkg::FRAC_BITS)
                   + $signed({{32{a_lane_r.c_real[31]}}, a_lane_r.c_real});
  // 2*zr*zi rescaled: one fewer shift bit
  assign im_full = (cross_r >>> (etf_pkg::FRAC_BITS - 1))
                   + $signed({{32{a_lane_r.c_imag[31]}}, a_lane_r.c_imag});

  always_comb begin
    b_lane_nxt = a_lane_r;
    if (a_act_r) begin
      if (esc) begin
        b_lane_nxt.done  = 1'b1;
        b_lane_nxt.count = IDX_C;
      end else begin
        b_lane_nxt.z_real = sat32(re_full);
        b_lane_nxt.z_imag = sat32(im_full);
      end
    end
  end

  assign vld_o  = b_vld_r;
  assign lane_o = b_lane_r;

endmodule

`default_nettype wire

FILE: design/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Julia / Mandelbrot escape-time counter built as a chain of iteration cells.
// ----------------------------------------------------------------------------
// Path: every input beat passes both registers of each cell and then the
//   output register, the same path whatever max_iters or the point is.
// Throughput: one beat per cycle; each cell owns one iteration step and the
//   chain moves every cycle unless a held result blocks a full last stage.
// Reset: synchronous, active-low rst_n clears every valid bit in the chain
//   and the output register, and loads max_iters with 200.
`default_nettype none

module escape_time_fractal_iterator #(
  parameter int MAX_STAGES = etf_pkg::MAX_STAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire etf_pkg::etf_in_t in_data,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output etf_pkg::etf_out_t     out_data,
  // max_iters write port
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  // Cell k runs iteration step k. Steps at or past max_iters pass the lane
  // through untouched; limits above the chain length are clamped simply
  // because there is no cell for those steps.

  logic [7:0]         max_iters_r;

  logic               vld   [MAX_STAGES+1];
  etf_pkg::etf_lane_t lane  [MAX_STAGES+1];

  logic               out_free;
  logic               en;
  logic               out_valid_r;
  etf_pkg::etf_out_t  out_data_r;

  // The chain may advance when the output register can take a beat, or
  // when the last cell holds nothing that would be pushed into it.
  assign out_free = !out_valid_r || !out_stall;
  assign en       = out_free || !vld[MAX_STAGES];
  assign in_stall = !en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iters_r <= etf_pkg::MAX_ITERS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_iters_r <= cfg_data;
    end
  end

  // chain entry: fresh point, not yet escaped
  assign vld[0]          = in_valid;
  assign lane[0].c_real  = in_data.c_real;
  assign lane[0].c_imag  = in_data.c_imag;
  assign lane[0].z_real  = in_data.z_real;
  assign lane[0].z_imag  = in_data.z_imag;
  assign lane[0].done    = 1'b0;
  assign lane[0].count   = 8'd0;

  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    etf_cell #(
      .IDX (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .limit  (max_iters_r),
      .vld_i  (vld[k]),
      .lane_i (lane[k]),
      .vld_o  (vld[k+1]),
      .lane_o (lane[k+1])
    );
  end

  // Output register. A point that never escaped keeps count 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld[MAX_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r.escape_count <= lane[MAX_STAGES].count;
      out_data_r.in_set       <= !lane[MAX_STAGES].done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: design/etf_checker.sv
// ----------------------------------------------------------------------------
// etf_checker
// Port-level checks on the escape-time iterator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "escape_time_fractal_iterator_defines.svh"

module etf_checker #(
  parameter int MAX_STAGES = etf_pkg::MAX_STAGES_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire etf_pkg::etf_out_t out_data
);

  // held result beat does not move
  `ETF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a point inside the set never carries a count
  `ETF_ASSERT_NOW(a_in_set_cnt, out_valid && out_data.in_set, out_data.escape_count == 8'd0)

  // escape step always names an existing cell
  `ETF_ASSERT_NOW(a_cnt_range, out_valid, out_data.escape_count < 8'(MAX_STAGES))

  // empty output register means the input side is open
  `ETF_ASSERT_NOW(a_no_block, !out_valid, !in_stall)

  // no result right out of reset
  `ETF_ASSERT_NOW(a_rst_clear, !$past(rst_n), !out_valid)

endmodule

bind escape_time_fractal_iterator etf_checker #(
  .MAX_STAGES (MAX_STAGES)
) u_etf_checker (.*);

`default_nettype wire
